// ===== src/marq_pkg.sv =====
// Shared types, widths and codes for the scrolling image marquee.
`default_nettype none
package marq_pkg;
    // Default store extent
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    // Field and state widths
    localparam int OP_W       = 2;
    localparam int COL_W      = 6;
    localparam int ROW_W      = 6;
    localparam int PIX_W      = 24;
    localparam int SHOWN_W    = 7;
    localparam int MODE_W     = 2;
    localparam int SIZE_W     = 7;
    localparam int GAP_W      = 6;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    // Scroll offset: image extent (up to 127) plus gap (up to 63)
    localparam int OFS_W      = 8;
    // Coordinate plus offset before reduction
    localparam int SUM_W      = 9;
    localparam int SHIFT_W    = 4;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    localparam logic [MODE_W-1:0] MODE_STATIC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HORIZ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VERT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_GAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_COLOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE     = 3'd6;

    typedef struct packed {
        logic cap;
        logic exec;
        logic step;
        logic rd;
        logic load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic scroll;
        logic mod_last;
        logic out_free;
    } t_status;
endpackage
`default_nettype wire

// ===== src/marq_in_if.sv =====
// Input item channel: valid/ready handshake and request payload.
`default_nettype none
interface marq_in_if;
    import marq_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [PIX_W-1:0]  pixel_in;

    modport src (output valid, output op, output col, output row, output pixel_in,
                 input ready);
    modport snk (input valid, input op, input col, input row, input pixel_in,
                 output ready);
endinterface
`default_nettype wire

// ===== src/marq_out_if.sv =====
// Result channel: valid/ready handshake and result payload.
`default_nettype none
interface marq_out_if;
    import marq_pkg::*;
    logic               valid;
    logic               ready;
    logic               rendered;
    logic               frame_valid;
    logic [SHOWN_W-1:0] shown_offset;
    logic [PIX_W-1:0]   pixel_out;

    modport src (output valid, output rendered, output frame_valid, output shown_offset,
                 output pixel_out, input ready);
    modport snk (input valid, input rendered, input frame_valid, input shown_offset,
                 input pixel_out, output ready);
endinterface
`default_nettype wire

// ===== src/scrolling_image_marquee.sv =====
// Top level of the scrolling image marquee: controller, datapath and checks.
`default_nettype none
// Scrolling image marquee. One transaction in gives exactly one result transaction out.
// Load the image with write-pixel transactions, then drive ticks; a read returns the
// 64 x 64 canvas colour at (col,row) for the offset captured at the last render, black
// before the first render, the padding colour in the padding band and black outside the
// image. The user must write configuration through the plain write port only while
// the block is idle; the block itself does not enforce this. Sequence: tick, write and
// the undefined op pass through accept, execute and load; a read in static mode passes
// through accept, execute, read and load (the image RAM read is registered); a read in
// horizontal or vertical mode adds a remainder phase before the read, as the column or
// row is reduced modulo image extent plus gap by a restoring remainder unit doing two
// steps a cycle. Load waits while the output register is full. A new transaction is
// accepted as soon as the previous result sits in the output register, even if it has
// not been taken yet; the next result waits for that register.
// The image store has no reset and needs no clearing pass: read only written pixels.
module scrolling_image_marquee #(
    parameter int MAX_WIDTH  = marq_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = marq_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [marq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [marq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    marq_in_if.snk                          i_item,
    marq_out_if.src                         o_res
);
    import marq_pkg::*;

    t_cmd    cmd;
    t_status st;
    logic    ready;

    // sequence each transaction through execute, remainder, read and load
    marq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_st    (st),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    // hold configuration, scroll state, image store and the output register
    marq_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_item.op),
        .i_col          (i_item.col),
        .i_row          (i_item.row),
        .i_pixel_in     (i_item.pixel_in),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_rendered     (o_res.rendered),
        .o_frame_valid  (o_res.frame_valid),
        .o_shown_offset (o_res.shown_offset),
        .o_pixel_out    (o_res.pixel_out)
    );

    assign i_item.ready = ready;

`ifndef SYNTHESIS
    // never overwrite a result that has not been taken
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> st.out_free)
        else $error("result loaded over an untaken result");

    // a rendering tick always reports a valid frame
    a_render_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.rendered) |-> o_res.frame_valid)
        else $error("rendered without frame_valid");

    // only one transaction in flight
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("second transaction accepted while busy");
`endif
endmodule
`default_nettype wire

// ===== src/marq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module marq_ram #(
    parameter int WIDTH = marq_pkg::PIX_W,
    parameter int DEPTH = marq_pkg::MAX_WIDTH_DEF * marq_pkg::MAX_HEIGHT_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== src/marq_ctrl.sv =====
// Controller state machine: sequences accept, execute, remainder, read and load.
`default_nettype none
module marq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  marq_pkg::t_status i_st,
    output logic              o_ready,
    output marq_pkg::t_cmd    o_cmd
);
    import marq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_MOD  = 5'b00100,
        S_READ = 5'b01000,
        S_LOAD = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_st.op == OP_READ) begin
                    n_state = i_st.scroll ? S_MOD : S_READ;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_MOD: begin
                o_cmd.step = 1'b1;
                if (i_st.mod_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                // hold the result until the output register frees up
                if (i_st.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
endmodule
`default_nettype wire

// ===== src/marq_dp.sv =====
// Datapath: configuration, scroll state, remainder unit, image store and output register.
`default_nettype none
module marq_dp #(
    parameter int MAX_WIDTH  = marq_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = marq_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  marq_pkg::t_cmd                i_cmd,
    output marq_pkg::t_status             o_st,
    input  logic                          i_cfg_we,
    input  logic [marq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [marq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [marq_pkg::OP_W-1:0]     i_op,
    input  logic [marq_pkg::COL_W-1:0]    i_col,
    input  logic [marq_pkg::ROW_W-1:0]    i_row,
    input  logic [marq_pkg::PIX_W-1:0]    i_pixel_in,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_rendered,
    output logic                          o_frame_valid,
    output logic [marq_pkg::SHOWN_W-1:0]  o_shown_offset,
    output logic [marq_pkg::PIX_W-1:0]    o_pixel_out
);
    import marq_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_MEM  = 2'd2
    } t_src;

    // configuration
    logic [MODE_W-1:0] r_mode;
    logic [SIZE_W-1:0] r_img_w, r_img_h;
    logic [GAP_W-1:0]  r_gap;
    logic [PIX_W-1:0]  r_pad_color;
    logic [TICK_W-1:0] r_step, r_pause;

    // scroll state
    logic [OFS_W-1:0]  r_scroll_ofs, n_scroll_ofs;
    logic [OFS_W-1:0]  r_frame_ofs, n_frame_ofs;
    logic [TICK_W-1:0] r_tick_cnt, n_tick_cnt;
    logic              r_has_frame, n_has_frame;
    logic              r_scrolling, n_scrolling;
    logic              n_render;

    // captured item
    t_op               r_op;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [PIX_W-1:0]  r_pix_in;

    // remainder unit
    logic [SUM_W-1:0]   r_rem;
    logic [SHIFT_W-1:0] r_k;
    logic [SUM_W-1:0]   rem_a, rem_b;

    // pending result
    t_src r_src, n_src;
    logic r_rend;

    // output register
    logic               r_ovalid;
    logic               r_o_rend, r_o_frame;
    logic [SHOWN_W-1:0] r_o_shown;
    logic [PIX_W-1:0]   r_o_pix;

    logic               horiz, vert, scroll;
    logic [SIZE_W-1:0]  eff_w, eff_h;
    logic [OFS_W-1:0]   ext, ofs_inc;
    logic [TICK_W-1:0]  tick_inc;
    logic [SUM_W-1:0]   xp, yp;
    logic               x_out, y_out;
    logic               wr_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [PIX_W-1:0]   ram_q;
    logic [PIX_W-1:0]   load_pix;

    function automatic logic [SUM_W-1:0] rem_step(input logic [SUM_W-1:0]   r,
                                                 input logic [OFS_W-1:0]   e,
                                                 input logic [SHIFT_W-1:0] k);
        logic [SUM_W+OFS_W-1:0] d;
        logic [SUM_W+OFS_W-1:0] t;
        d = (SUM_W + OFS_W)'(e) << k;
        t = (SUM_W + OFS_W)'(r);
        if (t >= d) begin
            t = t - d;
        end
        return t[SUM_W-1:0];
    endfunction

    assign horiz  = (r_mode == MODE_HORIZ);
    assign vert   = (r_mode == MODE_VERT);
    assign scroll = horiz | vert;

    assign eff_w = (r_img_w == '0) ? SIZE_W'(1) :
                   ((32'(r_img_w) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : r_img_w);
    assign eff_h = (r_img_h == '0) ? SIZE_W'(1) :
                   ((32'(r_img_h) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : r_img_h);
    assign ext      = OFS_W'(horiz ? eff_w : eff_h) + OFS_W'(r_gap);
    assign ofs_inc  = r_scroll_ofs + OFS_W'(1);
    assign tick_inc = r_tick_cnt + TICK_W'(1);

    // tick handling
    always_comb begin
        n_scroll_ofs = r_scroll_ofs;
        n_frame_ofs  = r_frame_ofs;
        n_tick_cnt   = r_tick_cnt;
        n_has_frame  = r_has_frame;
        n_scrolling  = r_scrolling;
        n_render     = 1'b0;
        if (i_cmd.exec && (r_op == OP_TICK)) begin
            if ((!scroll && !r_has_frame) || (scroll && r_scrolling)) begin
                if (!scroll) begin
                    n_render = 1'b1;
                end else begin
                    n_tick_cnt = tick_inc;
                    n_render   = (tick_inc >= r_step) || !r_has_frame;
                end
                if (n_render) begin
                    n_tick_cnt  = '0;
                    n_frame_ofs = r_scroll_ofs;
                    n_has_frame = 1'b1;
                    if (scroll) begin
                        if (ofs_inc >= ext) begin
                            n_scroll_ofs = '0;
                            if (r_pause != '0) begin
                                n_scrolling = 1'b0;
                            end
                        end else begin
                            n_scroll_ofs = ofs_inc;
                        end
                    end
                end
            end else if (scroll && !r_scrolling) begin
                if (tick_inc >= r_pause) begin
                    n_tick_cnt  = '0;
                    n_scrolling = 1'b1;
                end else begin
                    n_tick_cnt = tick_inc;
                end
            end
        end
    end

    // two restoring steps a cycle
    assign rem_a = rem_step(r_rem, ext, r_k);
    assign rem_b = rem_step(rem_a, ext, r_k - SHIFT_W'(1));

    // canvas lookup
    assign xp    = horiz ? r_rem : SUM_W'(r_col);
    assign yp    = vert ? r_rem : SUM_W'(r_row);
    assign x_out = (xp >= SUM_W'(eff_w));
    assign y_out = (yp >= SUM_W'(eff_h));

    always_comb begin
        if (!r_has_frame) begin
            n_src = SRC_ZERO;
        end else if ((horiz && x_out) || (vert && y_out)) begin
            n_src = SRC_PAD;
        end else if (x_out || y_out) begin
            n_src = SRC_ZERO;
        end else begin
            n_src = SRC_MEM;
        end
    end

    assign rd_addr = AW'(32'(yp) * 32'(MAX_WIDTH) + 32'(xp));
    assign wr_addr = AW'(32'(r_row) * 32'(MAX_WIDTH) + 32'(r_col));
    assign wr_en   = i_cmd.exec && (r_op == OP_WRITE) &&
                     (32'(r_col) < MAX_WIDTH) && (32'(r_row) < MAX_HEIGHT);

    marq_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_image (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (r_pix_in),
        .i_re    (i_cmd.rd),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_comb begin
        case (r_src)
            SRC_PAD: load_pix = r_pad_color;
            SRC_MEM: load_pix = ram_q;
            default: load_pix = '0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_STATIC;
            r_img_w      <= SIZE_W'(64);
            r_img_h      <= SIZE_W'(64);
            r_gap        <= '0;
            r_pad_color  <= '0;
            r_step       <= TICK_W'(1);
            r_pause      <= '0;
            r_scroll_ofs <= '0;
            r_frame_ofs  <= '0;
            r_tick_cnt   <= '0;
            r_has_frame  <= 1'b0;
            r_scrolling  <= 1'b1;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:      r_mode      <= i_cfg_data[MODE_W-1:0];
                    CFG_WIDTH:     r_img_w     <= i_cfg_data[SIZE_W-1:0];
                    CFG_HEIGHT:    r_img_h     <= i_cfg_data[SIZE_W-1:0];
                    CFG_PAD_GAP:   r_gap       <= i_cfg_data[GAP_W-1:0];
                    CFG_PAD_COLOR: r_pad_color <= i_cfg_data[PIX_W-1:0];
                    CFG_STEP:      r_step      <= i_cfg_data[TICK_W-1:0];
                    CFG_PAUSE:     r_pause     <= i_cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            r_scroll_ofs <= n_scroll_ofs;
            r_frame_ofs  <= n_frame_ofs;
            r_tick_cnt   <= n_tick_cnt;
            r_has_frame  <= n_has_frame;
            r_scrolling  <= n_scrolling;
            if (i_cmd.load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op     <= t_op'(i_op);
            r_col    <= i_col;
            r_row    <= i_row;
            r_pix_in <= i_pixel_in;
        end
        if (i_cmd.exec) begin
            r_src  <= SRC_ZERO;
            r_rend <= n_render;
            r_rem  <= SUM_W'(horiz ? r_col : r_row) + SUM_W'(r_frame_ofs);
            r_k    <= SHIFT_W'(SUM_W);
        end
        if (i_cmd.step) begin
            r_rem <= rem_b;
            r_k   <= r_k - SHIFT_W'(2);
        end
        if (i_cmd.rd) begin
            r_src <= n_src;
        end
        if (i_cmd.load) begin
            r_o_rend  <= r_rend;
            r_o_frame <= r_has_frame;
            r_o_shown <= r_frame_ofs[SHOWN_W-1:0];
            r_o_pix   <= load_pix;
        end
    end

    assign o_st.op       = r_op;
    assign o_st.scroll   = scroll;
    assign o_st.mod_last = (r_k == SHIFT_W'(1));
    assign o_st.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid    = r_ovalid;
    assign o_rendered     = r_o_rend;
    assign o_frame_valid  = r_o_frame;
    assign o_shown_offset = r_o_shown;
    assign o_pixel_out    = r_o_pix;
endmodule
`default_nettype wire
